// File: sv/wmss_pkg.sv
// shared types and constants for the windowed maximum subsequence sum unit
package wmss_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SCORE_W  = 32;
  localparam int CFG_W    = 7;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // partial window maximum travelling down the cell row
  typedef struct packed {
    logic                      tv;
    logic [CFG_W-1:0]          rem;
    logic signed [SCORE_W-1:0] acc;
  } token_t;

  // one stored past score
  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

endpackage

// File: sv/wmss_in_if.sv
// sample channel interface
interface wmss_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [wmss_pkg::SAMPLE_W-1:0]     sample;
  logic                                     seq_last;

  modport source (output valid, output sample, output seq_last, input ready);
  modport sink   (input valid, input sample, input seq_last, output ready);
endinterface

// File: sv/wmss_out_if.sv
// result channel interface
interface wmss_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [wmss_pkg::SCORE_W-1:0]     score;
  logic signed [wmss_pkg::SCORE_W-1:0]     best_so_far;
  logic                                    is_final;

  modport source (output valid, output score, output best_so_far, output is_final,
                  input ready);
  modport sink   (input valid, input score, input best_so_far, input is_final,
                  output ready);
endinterface

// File: sv/wmss_cell.sv
// one window cell: holds a past score and folds it into the passing maximum
module wmss_cell (
  input  logic                clk,
  input  logic                rst,
  input  wmss_pkg::cell_ctl_t ctl,
  input  wmss_pkg::entry_t    ent_i,
  output wmss_pkg::entry_t    ent_o,
  input  wmss_pkg::token_t    tok_i,
  output wmss_pkg::token_t    tok_o
);

  logic in_span;
  logic take;

  assign in_span = (tok_i.rem != '0) && ent_o.valid;
  assign take    = in_span && (ent_o.score > tok_i.acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_o.tv <= 1'b0;
    end else begin
      tok_o.tv <= tok_i.tv;
    end
    tok_o.acc <= take ? ent_o.score : tok_i.acc;
    tok_o.rem <= (tok_i.rem != '0) ? tok_i.rem - 1'b1 : tok_i.rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_o.valid <= 1'b0;
    end else if (ctl.clear) begin
      ent_o.valid <= 1'b0;
    end else if (ctl.shift) begin
      ent_o.valid <= ent_i.valid;
    end
    if (ctl.shift) begin
      ent_o.score <= ent_i.score;
    end
  end

endmodule

// File: sv/windowed_max_subsequence_sum_unit.sv
// top level: windowed maximum subsequence sum over a row of score cells
//
//   channel   dir  signals                                  width
//   samples   in   valid ready sample seq_last              16 + 1
//   results   out  valid ready score best_so_far is_final   32 + 32 + 1
//   cfg       in   cfg_we cfg_data (window_k)               7
//
// per sample, the window maximum walks the cell row one cell per cycle, is then
// added to the sample and saturated into score_q, and then committed.
// the commit waits while the result register is full and not taken; a new
// sample is accepted as soon as the previous one has committed.
// rst is synchronous: window_k returns to 1, cells empty, best to its minimum.
module windowed_max_subsequence_sum_unit #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  wmss_in_if.sink                       samples,
  wmss_out_if.source                    results,
  input  logic                          cfg_we,
  input  logic [wmss_pkg::CFG_W-1:0]    cfg_data
);

  localparam logic [wmss_pkg::CFG_W-1:0] SPAN_CAP =
    (WINDOW_MAX > 127) ? 7'd127 : wmss_pkg::CFG_W'(WINDOW_MAX);

  wmss_pkg::state_t state, state_next;

  logic [wmss_pkg::CFG_W-1:0]               window_k;
  logic [wmss_pkg::CFG_W-1:0]               span;
  logic signed [wmss_pkg::SAMPLE_W-1:0]     sample_q;
  logic                                     last_q;
  logic signed [wmss_pkg::SCORE_W-1:0]      score_q;
  logic signed [wmss_pkg::SCORE_W-1:0]      score_next;
  logic signed [wmss_pkg::SCORE_W-1:0]      best;
  logic signed [wmss_pkg::SCORE_W-1:0]      best_next;
  logic signed [wmss_pkg::SCORE_W:0]        sum;
  logic                                     accept;
  logic                                     commit;
  logic                                     res_valid;
  logic signed [wmss_pkg::SCORE_W-1:0]      res_score;
  logic signed [wmss_pkg::SCORE_W-1:0]      res_best;
  logic                                     res_final;
  wmss_pkg::cell_ctl_t                      ctl;
  wmss_pkg::token_t                         tok [0:WINDOW_MAX];
  wmss_pkg::entry_t                         ent [0:WINDOW_MAX];

  // zero means one, and nothing beyond the cell row
  always_comb begin
    span = (window_k > SPAN_CAP) ? SPAN_CAP : window_k;
    if (window_k == '0) begin
      span = wmss_pkg::CFG_W'(1);
    end
  end

  assign accept = samples.valid && samples.ready;

  // gain is never negative, so only the upper limit can be hit
  assign sum = {{(wmss_pkg::SCORE_W + 1 - wmss_pkg::SAMPLE_W){sample_q[wmss_pkg::SAMPLE_W-1]}},
                sample_q}
             + {tok[WINDOW_MAX].acc[wmss_pkg::SCORE_W-1], tok[WINDOW_MAX].acc};
  assign score_next = (sum > $signed({1'b0, wmss_pkg::SCORE_MAX})) ? wmss_pkg::SCORE_MAX
                                                                   : sum[wmss_pkg::SCORE_W-1:0];
  assign best_next  = (score_q > best) ? score_q : best;

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    commit        = 1'b0;
    case (state)
      wmss_pkg::ST_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          state_next = wmss_pkg::ST_SCAN;
        end
      end
      wmss_pkg::ST_SCAN: begin
        if (tok[WINDOW_MAX].tv) begin
          state_next = wmss_pkg::ST_COMMIT;
        end
      end
      wmss_pkg::ST_COMMIT: begin
        if (!res_valid || results.ready) begin
          commit     = 1'b1;
          state_next = wmss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wmss_pkg::ST_IDLE;
      end
    endcase
    ctl.shift = commit && !last_q;
    ctl.clear = commit && last_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wmss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_k <= wmss_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      window_k <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= samples.sample;
      last_q   <= samples.seq_last;
    end
    if (state == wmss_pkg::ST_SCAN && tok[WINDOW_MAX].tv) begin
      score_q <= score_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best <= wmss_pkg::SCORE_MIN;
    end else if (commit) begin
      best <= last_q ? wmss_pkg::SCORE_MIN : best_next;
    end
  end

  // result register parts the output handshake from the cell row
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
    if (commit) begin
      res_score <= score_q;
      res_best  <= best_next;
      res_final <= last_q;
    end
  end

  assign results.valid       = res_valid;
  assign results.score       = res_score;
  assign results.best_so_far = res_best;
  assign results.is_final    = res_final;

  // token enters at the head on the transfer; newest score enters cell 0
  assign tok[0] = '{tv: accept, rem: span, acc: '0};
  assign ent[0] = '{valid: 1'b1, score: score_q};

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    wmss_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .ent_i (ent[i]),
      .ent_o (ent[i+1]),
      .tok_i (tok[i]),
      .tok_o (tok[i+1])
    );
  end

endmodule
